>>> src/lpmr_pkg.sv
// ----------------------------------------------------------------------------
// lpmr_pkg: shared types and constants for the length-prefixed message ring
// Ring geometry, command and status codes, beat structs and the
// controller/datapath handshake types.
// ----------------------------------------------------------------------------
package lpmr_pkg;

  localparam int RING_BYTES   = 4096;
  localparam int HEADER_BYTES = 4;

  // Memory address and pointer widths (pointers count modulo 2*RING_BYTES)
  localparam int ADDR_W = $clog2(RING_BYTES);
  localparam int PTR_W  = ADDR_W + 1;

  localparam int LEN_W  = 16;
  localparam int DATA_W = 8;

  // Only the low two header bytes ever hold nonzero length bits
  localparam int HDR_USED = (HEADER_BYTES < 2) ? 1 : 2;

  // Header byte index; one bit covers the one or two bytes that are moved
  localparam int IDX_W = 1;

  // Width of the fit check sum: used + header + length
  localparam int SUM_W = ((PTR_W > LEN_W) ? PTR_W : LEN_W) + 1;

  typedef enum logic [1:0] {
    CMD_WRITE_BEGIN = 2'd0,
    CMD_WRITE_BYTE  = 2'd1,
    CMD_READ_BEGIN  = 2'd2,
    CMD_READ_BYTE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_ORDER   = 2'd3
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    status_e           status;
    logic [LEN_W-1:0]  length_out;
    logic [DATA_W-1:0] data_out;
    logic              last;
    logic [PTR_W-1:0]  used_bytes;
  } out_item_t;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_DECODE,
    FSM_WHDR,
    FSM_WOPEN,
    FSM_RHDR_RD,
    FSM_RHDR_CAP,
    FSM_ROPEN,
    FSM_RBYTE,
    FSM_FINISH
  } fsm_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_STATUS,
    OP_WHDR,
    OP_WOPEN,
    OP_WBYTE,
    OP_RHDR_RD,
    OP_RHDR_CAP,
    OP_ROPEN,
    OP_RRD,
    OP_RBYTE,
    OP_FINISH
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    status_e status;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic write_active;
    logic read_active;
    logic empty;
    logic fits;
    logic hdr_last;
    logic out_free;
  } dp_stat_t;

endpackage

>>> src/lpmr_ctrl.sv
// ----------------------------------------------------------------------------
// lpmr_ctrl: command sequencer
// Steps one accepted command through header, payload and result phases and
// drives the datapath with one operation per cycle.
// ----------------------------------------------------------------------------
module lpmr_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lpmr_pkg::dp_stat_t stat_i,
  output lpmr_pkg::ctrl_cmd_t cmd_o
);
  import lpmr_pkg::*;

  fsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.status  = ST_OK;
    in_stall_o    = 1'b1;
    case (state_q)
      FSM_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.op = OP_ACCEPT;
          state_d  = FSM_DECODE;
        end
      end
      FSM_DECODE: begin
        state_d = FSM_FINISH;
        case (stat_i.cmd)
          CMD_WRITE_BEGIN: begin
            if (stat_i.write_active) begin
              cmd_o.op     = OP_STATUS;
              cmd_o.status = ST_ORDER;
            end else if (!stat_i.fits) begin
              cmd_o.op     = OP_STATUS;
              cmd_o.status = ST_NO_ROOM;
            end else begin
              state_d = FSM_WHDR;
            end
          end
          CMD_WRITE_BYTE: begin
            if (!stat_i.write_active) begin
              cmd_o.op     = OP_STATUS;
              cmd_o.status = ST_ORDER;
            end else begin
              cmd_o.op = OP_WBYTE;
            end
          end
          CMD_READ_BEGIN: begin
            if (stat_i.read_active) begin
              cmd_o.op     = OP_STATUS;
              cmd_o.status = ST_ORDER;
            end else if (stat_i.empty) begin
              cmd_o.op     = OP_STATUS;
              cmd_o.status = ST_EMPTY;
            end else begin
              state_d = FSM_RHDR_RD;
            end
          end
          default: begin
            if (!stat_i.read_active) begin
              cmd_o.op     = OP_STATUS;
              cmd_o.status = ST_ORDER;
            end else begin
              cmd_o.op = OP_RRD;
              state_d  = FSM_RBYTE;
            end
          end
        endcase
      end
      FSM_WHDR: begin
        cmd_o.op = OP_WHDR;
        if (stat_i.hdr_last) begin
          state_d = FSM_WOPEN;
        end
      end
      FSM_WOPEN: begin
        cmd_o.op = OP_WOPEN;
        state_d  = FSM_FINISH;
      end
      FSM_RHDR_RD: begin
        cmd_o.op = OP_RHDR_RD;
        state_d  = FSM_RHDR_CAP;
      end
      FSM_RHDR_CAP: begin
        cmd_o.op = OP_RHDR_CAP;
        state_d  = stat_i.hdr_last ? FSM_ROPEN : FSM_RHDR_RD;
      end
      FSM_ROPEN: begin
        cmd_o.op = OP_ROPEN;
        state_d  = FSM_FINISH;
      end
      FSM_RBYTE: begin
        cmd_o.op = OP_RBYTE;
        state_d  = FSM_FINISH;
      end
      FSM_FINISH: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_FINISH;
          state_d  = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

>>> src/lpmr_dp.sv
// ----------------------------------------------------------------------------
// lpmr_dp: ring datapath
// Byte memory, ring pointers, open-message cursors, command latch and the
// output register. Executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module lpmr_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lpmr_pkg::in_item_t   in_item_i,
  input  lpmr_pkg::ctrl_cmd_t  cmd_i,
  output lpmr_pkg::dp_stat_t   stat_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lpmr_pkg::out_item_t  out_item_o
);
  import lpmr_pkg::*;

  logic [DATA_W-1:0] mem_q [RING_BYTES];
  logic [DATA_W-1:0] rdata_q;

  logic             mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic             mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  in_item_t         item_q;
  out_item_t        res_q;
  out_item_t        out_q;
  logic             out_valid_q;
  logic [IDX_W-1:0] hdr_idx_q;
  logic [LEN_W-1:0] stored_q;

  logic [PTR_W-1:0] rd_ptr_q, wr_ptr_q, wr_cur_q, rd_cur_q, rd_next_q;
  logic [LEN_W-1:0] wr_rem_q, rd_rem_q;
  logic             wr_act_q, rd_act_q;

  logic [PTR_W-1:0] used;
  logic [SUM_W-1:0] need;
  logic [PTR_W-1:0] hdr_ptr;
  logic [LEN_W-1:0] deliver;
  logic [PTR_W-1:0] rd_body;

  assign used    = wr_ptr_q - rd_ptr_q;
  assign need    = SUM_W'(used) + SUM_W'(HEADER_BYTES) + SUM_W'(item_q.length);
  assign hdr_ptr = (cmd_i.op == OP_WHDR ? wr_ptr_q : rd_ptr_q) + PTR_W'(hdr_idx_q);
  assign deliver = (stored_q < item_q.length) ? stored_q : item_q.length;
  assign rd_body = rd_ptr_q + PTR_W'(HEADER_BYTES);

  assign stat_o.cmd          = item_q.cmd;
  assign stat_o.write_active = wr_act_q;
  assign stat_o.read_active  = rd_act_q;
  assign stat_o.empty        = (rd_ptr_q == wr_ptr_q);
  assign stat_o.fits         = !((HEADER_BYTES < 2) && (item_q.length[15:8] != '0)) &&
                               (need <= SUM_W'(RING_BYTES));
  assign stat_o.hdr_last     = (hdr_idx_q == IDX_W'(HDR_USED - 1));
  assign stat_o.out_free     = !out_valid_q || !out_stall_i;

  // Memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hdr_ptr[ADDR_W-1:0];
    mem_wdata = (hdr_idx_q == '0) ? item_q.length[7:0] : item_q.length[15:8];
    mem_re    = 1'b0;
    mem_raddr = hdr_ptr[ADDR_W-1:0];
    case (cmd_i.op)
      OP_WHDR: begin
        mem_we = 1'b1;
      end
      OP_WBYTE: begin
        mem_we    = 1'b1;
        mem_waddr = wr_cur_q[ADDR_W-1:0];
        mem_wdata = item_q.data_in;
      end
      OP_RHDR_RD: begin
        mem_re = 1'b1;
      end
      OP_RRD: begin
        mem_re    = 1'b1;
        mem_raddr = rd_cur_q[ADDR_W-1:0];
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_raddr];
    end
  end

  // Command latch, working result, header assembly
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_ACCEPT: begin
        item_q            <= in_item_i;
        res_q.status      <= ST_OK;
        res_q.length_out  <= '0;
        res_q.data_out    <= '0;
        res_q.last        <= 1'b0;
        res_q.used_bytes  <= '0;
        stored_q          <= '0;
      end
      OP_STATUS: begin
        res_q.status <= cmd_i.status;
      end
      OP_WOPEN: begin
        res_q.length_out <= item_q.length;
      end
      OP_RHDR_CAP: begin
        if (hdr_idx_q == '0) begin
          stored_q[7:0] <= rdata_q;
        end else begin
          stored_q[15:8] <= rdata_q;
        end
      end
      OP_ROPEN: begin
        res_q.length_out <= deliver;
      end
      OP_RBYTE: begin
        res_q.data_out <= rdata_q;
        res_q.last     <= (rd_rem_q == LEN_W'(1));
      end
      default: begin
        res_q.status <= res_q.status;
      end
    endcase
  end

  // Ring state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      wr_cur_q  <= '0;
      rd_cur_q  <= '0;
      rd_next_q <= '0;
      wr_rem_q  <= '0;
      rd_rem_q  <= '0;
      wr_act_q  <= 1'b0;
      rd_act_q  <= 1'b0;
      hdr_idx_q <= '0;
    end else begin
      case (cmd_i.op)
        OP_ACCEPT: begin
          hdr_idx_q <= '0;
        end
        OP_WHDR: begin
          hdr_idx_q <= hdr_idx_q + IDX_W'(1);
        end
        OP_RHDR_CAP: begin
          hdr_idx_q <= hdr_idx_q + IDX_W'(1);
        end
        OP_WOPEN: begin
          wr_cur_q <= wr_ptr_q + PTR_W'(HEADER_BYTES);
          wr_rem_q <= item_q.length;
          if (item_q.length == '0) begin
            wr_ptr_q <= wr_ptr_q + PTR_W'(HEADER_BYTES);
          end else begin
            wr_act_q <= 1'b1;
          end
        end
        OP_WBYTE: begin
          wr_cur_q <= wr_cur_q + PTR_W'(1);
          wr_rem_q <= wr_rem_q - LEN_W'(1);
          if (wr_rem_q == LEN_W'(1)) begin
            wr_ptr_q <= wr_cur_q + PTR_W'(1);
            wr_act_q <= 1'b0;
          end
        end
        OP_ROPEN: begin
          rd_cur_q  <= rd_body;
          rd_next_q <= rd_body + PTR_W'(stored_q);
          rd_rem_q  <= deliver;
          if (deliver == '0) begin
            rd_ptr_q <= rd_body + PTR_W'(stored_q);
          end else begin
            rd_act_q <= 1'b1;
          end
        end
        OP_RBYTE: begin
          rd_cur_q <= rd_cur_q + PTR_W'(1);
          rd_rem_q <= rd_rem_q - LEN_W'(1);
          if (rd_rem_q == LEN_W'(1)) begin
            rd_ptr_q <= rd_next_q;
            rd_act_q <= 1'b0;
          end
        end
        default: begin
          hdr_idx_q <= hdr_idx_q;
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_FINISH) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_FINISH) begin
      out_q.status     <= res_q.status;
      out_q.length_out <= res_q.length_out;
      out_q.data_out   <= res_q.data_out;
      out_q.last       <= res_q.last;
      out_q.used_bytes <= used;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

>>> src/length_prefixed_message_ring.sv
// ----------------------------------------------------------------------------
// length_prefixed_message_ring: byte ring of length-prefixed messages
// Input beats carry one command (write_begin, write_byte, read_begin,
// read_byte); every command returns exactly one output beat with status,
// length, data byte, last flag and the committed byte count.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Commands run one at a time. An accepted command is decoded; a refused one
// (order, room or an empty ring) goes straight to the finish step, the others
// first pass their header, open or byte steps. With the receiver not stalling,
// the next command can be accepted at the same edge as the output beat.
// These steps come from the single byte-wide memory port: each header and
// payload byte is one write, or one read plus a step to capture the data.
// The result sits in an output register, so the next command is accepted
// while a result still waits; if the receiver stalls, the block holds in its
// finish step until the output register frees up.
// Reset clears both pointers and all open-message state; the ring memory is
// not cleared, since only committed bytes are ever read.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lpmr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lpmr_pkg::out_item_t out_item_o
);
  import lpmr_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  lpmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  lpmr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (ctrl_cmd),
    .stat_o      (dp_stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
